FILE: src/hpt_pkg.sv
// Shared types, constants and command codes for the homogeneous point transform.
// Used by hpt_ctrl, hpt_dp and homogeneous_point_transform_top.
package hpt_pkg;

  localparam int FRAC_BITS_DEF  = 16;
  localparam int WORD_WIDTH_DEF = 32;
  localparam int FIELD_BITS     = 32;

  typedef enum logic [1:0] {
    CMD_LOAD    = 2'd0,
    CMD_COL_PT  = 2'd1,
    CMD_ROW_PT  = 2'd2,
    CMD_ROW_DIR = 2'd3
  } cmd_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_MAC,
    ST_CHECK,
    ST_DIV,
    ST_OUT
  } state_t;

  // controller -> datapath
  typedef struct packed {
    logic       capture;
    logic       load_elem;
    logic       mac_clear;
    logic       mac_step;
    logic       div_start;
    logic       div_step;
    logic       div_store;
    logic       out_load;
    logic [1:0] term;
    logic [1:0] coord;
  } dp_cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic w_zero;
  } dp_stat_t;

endpackage

FILE: src/hpt_ctrl.sv
// Controller for the homogeneous point transform: sequences MAC terms and divisions.
// Depends on hpt_pkg.
module hpt_ctrl #(
  parameter int QUO_BITS = 64
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  input  hpt_pkg::cmd_t     in_cmd,
  output logic              in_ready,
  output logic              out_valid,
  input  logic              out_ready,
  input  hpt_pkg::dp_stat_t stat,
  output hpt_pkg::dp_cmd_t  cmd
);

  localparam int CW = $clog2(QUO_BITS + 1);

  hpt_pkg::state_t state, state_next;
  logic [1:0]      term, term_next;
  logic [1:0]      coord, coord_next;
  logic [CW-1:0]   cnt, cnt_next;
  logic            ovalid, ovalid_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state  <= hpt_pkg::ST_IDLE;
      term   <= '0;
      coord  <= '0;
      cnt    <= '0;
      ovalid <= 1'b0;
    end else begin
      state  <= state_next;
      term   <= term_next;
      coord  <= coord_next;
      cnt    <= cnt_next;
      ovalid <= ovalid_next;
    end
  end

  always_comb begin
    state_next  = state;
    term_next   = term;
    coord_next  = coord;
    cnt_next    = cnt;
    ovalid_next = ovalid;
    if (out_ready) ovalid_next = 1'b0;
    cmd         = '0;
    cmd.term    = term;
    cmd.coord   = coord;
    in_ready    = 1'b0;
    unique case (state)
      hpt_pkg::ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          if (in_cmd == hpt_pkg::CMD_LOAD) begin
            cmd.load_elem = 1'b1;
          end else begin
            cmd.capture   = 1'b1;
            cmd.mac_clear = 1'b1;
            term_next     = '0;
            state_next    = hpt_pkg::ST_MAC;
          end
        end
      end
      hpt_pkg::ST_MAC: begin
        cmd.mac_step = 1'b1;
        term_next    = term + 2'd1;
        if (term == 2'd3) state_next = hpt_pkg::ST_CHECK;
      end
      hpt_pkg::ST_CHECK: begin
        coord_next = '0;
        cmd.coord  = '0;
        if (stat.w_zero) begin
          state_next = hpt_pkg::ST_OUT;
        end else begin
          cmd.div_start = 1'b1;
          cnt_next      = CW'(QUO_BITS);
          state_next    = hpt_pkg::ST_DIV;
        end
      end
      hpt_pkg::ST_DIV: begin
        if (cnt != '0) begin
          cmd.div_step = 1'b1;
          cnt_next     = cnt - CW'(1);
        end else begin
          cmd.div_store = 1'b1;
          if (coord == 2'd2) begin
            state_next = hpt_pkg::ST_OUT;
          end else begin
            coord_next    = coord + 2'd1;
            cmd.coord     = coord + 2'd1;
            cmd.div_start = 1'b1;
            cnt_next      = CW'(QUO_BITS);
          end
        end
      end
      hpt_pkg::ST_OUT: begin
        // wait until the output register is free
        if (!ovalid || out_ready) begin
          cmd.out_load = 1'b1;
          ovalid_next  = 1'b1;
          state_next   = hpt_pkg::ST_IDLE;
        end
      end
      default: state_next = hpt_pkg::ST_IDLE;
    endcase
  end

  assign out_valid = ovalid;

endmodule

FILE: src/hpt_dp.sv
// Datapath for the homogeneous point transform: matrix store, shared MAC,
// restoring divider and output register. Depends on hpt_pkg.
module hpt_dp #(
  parameter int FRAC_BITS  = hpt_pkg::FRAC_BITS_DEF,
  parameter int WORD_WIDTH = hpt_pkg::WORD_WIDTH_DEF,
  parameter int QUO_BITS   = 64
) (
  input  logic                        clk,
  input  logic                        rst,
  input  hpt_pkg::dp_cmd_t            cmd,
  output hpt_pkg::dp_stat_t           stat,
  input  hpt_pkg::cmd_t               in_cmd,
  input  logic [1:0]                  row_sel,
  input  logic [1:0]                  col_sel,
  input  logic signed [31:0]          elem_value,
  input  logic signed [31:0]          x_in,
  input  logic signed [31:0]          y_in,
  input  logic signed [31:0]          z_in,
  output logic signed [31:0]          x_out,
  output logic signed [31:0]          y_out,
  output logic signed [31:0]          z_out,
  output logic                        w_zero,
  output logic                        saturated
);

  localparam int PW   = 2 * WORD_WIDTH;        // product width
  localparam int AW   = PW + 3;                // sum of four products
  localparam int NW   = AW + FRAC_BITS;        // shifted dividend magnitude
  localparam int SATB = (WORD_WIDTH < hpt_pkg::FIELD_BITS) ? WORD_WIDTH : hpt_pkg::FIELD_BITS;
  localparam logic [WORD_WIDTH-1:0] ONE = WORD_WIDTH'(1) << FRAC_BITS;

  function automatic logic [WORD_WIDTH-1:0] to_word(input logic [31:0] f);
    return WORD_WIDTH'($signed({{(WORD_WIDTH+32){f[31]}}, f}));
  endfunction

  logic [WORD_WIDTH-1:0] mat [16];
  logic [WORD_WIDTH-1:0] src [3];
  hpt_pkg::cmd_t         mode;
  logic signed [AW-1:0]  acc [4];

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < 16; i++)
        mat[i] <= ((i % 4) == (i / 4)) ? ONE : '0;
    end else if (cmd.load_elem) begin
      mat[{row_sel, col_sel}] <= to_word(elem_value);
    end
  end

  // one term per cycle: four products (one per output) in parallel lanes
  logic [WORD_WIDTH-1:0] opnd;
  logic [WORD_WIDTH-1:0] coef [4];
  logic                  use_t [4];

  always_comb begin
    opnd = (cmd.term == 2'd3) ? ONE : src[cmd.term];
    for (int r = 0; r < 4; r++) begin
      if (mode == hpt_pkg::CMD_COL_PT) coef[r] = mat[{2'(r), cmd.term}];
      else                             coef[r] = mat[{cmd.term, 2'(r)}];
      use_t[r] = !(mode == hpt_pkg::CMD_ROW_DIR && cmd.term == 2'd3 && r < 3);
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      src[0] <= to_word(x_in);
      src[1] <= to_word(y_in);
      src[2] <= to_word(z_in);
      mode   <= in_cmd;
    end
    for (int r = 0; r < 4; r++) begin
      if (cmd.mac_clear) acc[r] <= '0;
      else if (cmd.mac_step && use_t[r])
        acc[r] <= acc[r] + AW'($signed(opnd) * $signed(coef[r]));
    end
  end

  assign stat.w_zero = (acc[3] == '0);

  // restoring divider, one quotient bit per cycle
  logic [AW-1:0]       dmag;
  logic [NW-1:0]       nsh;
  logic [NW:0]         rem;
  logic [QUO_BITS-1:0] quo;
  logic                neg;
  logic [1:0]          div_coord;
  logic [AW-1:0]       nsel_mag;
  logic [NW:0]         rem_sh;
  logic signed [AW-1:0] nsel;

  assign nsel     = acc[cmd.coord];
  assign nsel_mag = nsel[AW-1] ? AW'(-nsel) : AW'(nsel);
  assign rem_sh   = {rem[NW-1:0], nsh[NW-1]};

  always_ff @(posedge clk) begin
    if (cmd.div_start) begin
      dmag      <= acc[3][AW-1] ? AW'(-acc[3]) : AW'(acc[3]);
      nsh       <= {nsel_mag, {FRAC_BITS{1'b0}}};
      neg       <= nsel[AW-1] ^ acc[3][AW-1];
      div_coord <= cmd.coord;
      rem       <= '0;
      quo       <= '0;
    end else if (cmd.div_step) begin
      nsh <= nsh << 1;
      if (rem_sh >= (NW+1)'(dmag)) begin
        rem <= rem_sh - (NW+1)'(dmag);
        quo <= {quo[QUO_BITS-2:0], 1'b1};
      end else begin
        rem <= rem_sh;
        quo <= {quo[QUO_BITS-2:0], 1'b0};
      end
    end
  end

  // clip and sign the finished quotient
  logic [QUO_BITS-1:0] lim;
  logic                clip;
  logic [QUO_BITS-1:0] qv;
  logic [31:0]         res;
  assign lim  = (QUO_BITS'(1) << (SATB - 1)) - (neg ? QUO_BITS'(0) : QUO_BITS'(1));
  assign clip = quo > lim;
  assign qv   = clip ? lim : quo;
  assign res  = neg ? 32'(-qv) : 32'(qv);

  logic [31:0] qres [3];
  logic        sat_acc;

  always_ff @(posedge clk) begin
    if (cmd.capture) sat_acc <= 1'b0;
    if (cmd.div_store) begin
      qres[div_coord] <= res;
      if (clip) sat_acc <= 1'b1;
    end
    if (cmd.out_load) begin
      if (stat.w_zero) begin
        x_out <= '0; y_out <= '0; z_out <= '0;
        w_zero <= 1'b1; saturated <= 1'b0;
      end else begin
        x_out <= qres[0]; y_out <= qres[1]; z_out <= qres[2];
        w_zero <= 1'b0; saturated <= sat_acc;
      end
    end
  end

endmodule

FILE: src/homogeneous_point_transform_top.sv
// Homogeneous 4x4 point transform: Q16.16 matrix times (x,y,z,1), divided by w.
// Sequence: an item runs the four MAC terms, a w check, three restoring divides (x, y, z)
//   and the output load (quotient width QUO_BITS = 83 at defaults); zero w skips the divides.
// One item is taken at a time, since input is accepted only while idle; the pace is set
//   by the bit-serial restoring divider, and a stalled result holds the next one.
// A load item writes one matrix element and gives no result.
// Reset (synchronous, rst high) loads identity into the matrix and empties the output.
module homogeneous_point_transform_top #(
  parameter int FRAC_BITS  = hpt_pkg::FRAC_BITS_DEF,
  parameter int WORD_WIDTH = hpt_pkg::WORD_WIDTH_DEF
) (
  input  logic         clk,
  input  logic         rst,
  input  logic         s_tvalid,
  output logic         s_tready,
  input  logic [135:0] s_tdata,  // cmd[1:0], row_sel[3:2], col_sel[5:4], elem_value[37:6],
                                 // x_in[69:38], y_in[101:70], z_in[133:102], zero pad
  output logic         m_tvalid,
  input  logic         m_tready,
  output logic [95:0]  m_tdata,  // x_out[31:0], y_out[63:32], z_out[95:64]
  output logic [1:0]   m_tuser   // w_zero[0], saturated[1]
);

  // quotient register wide enough to detect any overflow
  localparam int QUO_BITS = 2 * WORD_WIDTH + 3 + FRAC_BITS;

  hpt_pkg::dp_cmd_t  dcmd;
  hpt_pkg::dp_stat_t dstat;
  hpt_pkg::cmd_t     in_cmd;
  logic signed [31:0] x_o, y_o, z_o;
  logic              wz, sat;

  assign in_cmd = hpt_pkg::cmd_t'(s_tdata[1:0]);

  hpt_ctrl #(.QUO_BITS(QUO_BITS)) u_ctrl (
    .clk(clk), .rst(rst),
    .in_valid(s_tvalid), .in_cmd(in_cmd), .in_ready(s_tready),
    .out_valid(m_tvalid), .out_ready(m_tready),
    .stat(dstat), .cmd(dcmd)
  );

  hpt_dp #(.FRAC_BITS(FRAC_BITS), .WORD_WIDTH(WORD_WIDTH), .QUO_BITS(QUO_BITS)) u_dp (
    .clk(clk), .rst(rst), .cmd(dcmd), .stat(dstat), .in_cmd(in_cmd),
    .row_sel(s_tdata[3:2]), .col_sel(s_tdata[5:4]),
    .elem_value(s_tdata[37:6]), .x_in(s_tdata[69:38]),
    .y_in(s_tdata[101:70]), .z_in(s_tdata[133:102]),
    .x_out(x_o), .y_out(y_o), .z_out(z_o), .w_zero(wz), .saturated(sat)
  );

  assign m_tdata = {z_o, y_o, x_o};
  assign m_tuser = {sat, wz};

`ifndef SYNTH
  // a zero-w result never reports saturation
  a_wz_nosat: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tuser[0] |-> !m_tuser[1]) else $error("w_zero with saturated");
  // a zero-w result carries zero coordinates
  a_wz_zero: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tuser[0] |-> m_tdata == '0) else $error("w_zero with data");
  // a stalled result holds its data
  a_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> $stable(m_tdata) && $stable(m_tuser))
    else $error("result changed under stall");
`endif

endmodule
